>>> design/websocket_client_frame_masker_assert.svh
// ----------------------------------------------------------------------------
// websocket client frame masker assertion macros
// clocked assertion helpers used by the top design file
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_CLIENT_FRAME_MASKER_ASSERT_SVH
`define WEBSOCKET_CLIENT_FRAME_MASKER_ASSERT_SVH

// property must hold at every clock edge outside reset
`define WSCFM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define WSCFM_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> design/wscfm_pkg.sv
// ----------------------------------------------------------------------------
// wscfm_pkg
// types, constants and helpers of the websocket client frame masker
// ----------------------------------------------------------------------------
package wscfm_pkg;

   localparam logic [7:0]  FRAME_FIN_TEXT = 8'h81;
   localparam logic [7:0]  LEN_EXT16      = 8'hFE;
   localparam logic [7:0]  MASK_BIT       = 8'h80;
   localparam logic [31:0] KEY_RESET      = 32'h1234_5678;
   localparam logic [15:0] SHORT_LEN_MAX  = 16'd125;
   localparam int          MAX_RESULTS    = 9;
   localparam int          SEQ_W          = $clog2(MAX_RESULTS);

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        start_of_frame;
      logic [15:0] frame_length;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_done;
      logic       stray_error;
   } rsp_type;

   typedef struct packed {
      logic [15:0] bytes_left;
      logic [1:0]  mask_index;
      logic        in_frame;
   } frame_state_type;

   function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = key[31:24];
         2'd1:    b = key[23:16];
         2'd2:    b = key[15:8];
         default: b = key[7:0];
      endcase
      return b;
   endfunction

endpackage

>>> design/websocket_client_frame_masker.sv
// a taken request is held in the item register; results leave via the result register
// throughput: one result per cycle through the single result register, while not stalled by rsp_ready
// a payload request gives one result, a start request 6 to 9 results (header, first byte)
// reset: synchronous, active high; frame closed, counters zero, key 0x12345678
// ----------------------------------------------------------------------------
// websocket_client_frame_masker
// frames payload bytes into masked websocket client text frames
// ----------------------------------------------------------------------------
`include "websocket_client_frame_masker_assert.svh"

module websocket_client_frame_masker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  wscfm_pkg::req_type   req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output wscfm_pkg::rsp_type   rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [31:0]          csr_data
);

   localparam logic [wscfm_pkg::SEQ_W-1:0] SEQ_ONE = wscfm_pkg::SEQ_W'(1);
   localparam logic [wscfm_pkg::SEQ_W-1:0] SEQ_TOP =
      wscfm_pkg::SEQ_W'(wscfm_pkg::MAX_RESULTS - 1);

   logic                              item_valid_ff;
   logic                              item_valid_in;
   wscfm_pkg::req_type                item_ff;
   logic [wscfm_pkg::SEQ_W-1:0]       seq_ff;
   logic [wscfm_pkg::SEQ_W-1:0]       seq_in;
   wscfm_pkg::frame_state_type        state_ff;
   wscfm_pkg::frame_state_type        state_in;
   wscfm_pkg::frame_state_type        state_next;
   logic [31:0]                       mask_key_ff;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   wscfm_pkg::rsp_type                rsp_ff;
   wscfm_pkg::rsp_type                result;
   logic                              produce;
   logic                              req_take;

   wscfm_format u_format (
      .item       (item_ff),
      .seq        (seq_ff),
      .state      (state_ff),
      .key        (mask_key_ff),
      .result     (result),
      .state_next (state_next)
   );

   assign produce   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || (produce && result.run_last);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      item_valid_in = item_valid_ff;
      seq_in        = seq_ff;
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (produce) begin
         rsp_valid_in = 1'b1;
         if (result.run_last) begin
            seq_in        = '0;
            state_in      = state_next;
            item_valid_in = 1'b0;
         end else begin
            seq_in = seq_ff + SEQ_ONE;
         end
      end
      if (req_take) begin
         item_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         seq_ff        <= '0;
         state_ff      <= '0;
         mask_key_ff   <= wscfm_pkg::KEY_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         seq_ff        <= seq_in;
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            mask_key_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= req_data;
      end
      if (produce) begin
         rsp_ff <= result;
      end
   end

   `WSCFM_NEVER(a_seq_range, clock, reset, seq_ff > SEQ_TOP, "result position out of range")
   `WSCFM_ASSERT(a_take_on_last, clock, reset,
                 (req_take && item_valid_ff) |-> (produce && result.run_last),
                 "request taken while results pending")
   `WSCFM_ASSERT(a_open_has_bytes, clock, reset,
                 state_ff.in_frame |-> (state_ff.bytes_left != 16'd0),
                 "open frame with no bytes left")
   `WSCFM_ASSERT(a_stray_single, clock, reset,
                 (rsp_valid_ff && rsp_ff.stray_error) |-> (rsp_ff.run_last && !rsp_ff.frame_done),
                 "stray result not single")

endmodule

>>> design/wscfm_format.sv
// ----------------------------------------------------------------------------
// wscfm_format
// picks the result byte for one position of the held request and the frame
// state that follows once its last result is out
// ----------------------------------------------------------------------------
module wscfm_format (
   input  wscfm_pkg::req_type                item,
   input  logic [wscfm_pkg::SEQ_W-1:0]       seq,
   input  wscfm_pkg::frame_state_type        state,
   input  logic [31:0]                       key,
   output wscfm_pkg::rsp_type                result,
   output wscfm_pkg::frame_state_type        state_next
);

   localparam logic [wscfm_pkg::SEQ_W-1:0] SEQ_W_ONE   = wscfm_pkg::SEQ_W'(1);
   localparam logic [wscfm_pkg::SEQ_W-1:0] SEQ_W_SIX   = wscfm_pkg::SEQ_W'(6);
   localparam logic [wscfm_pkg::SEQ_W-1:0] SEQ_W_EIGHT = wscfm_pkg::SEQ_W'(8);

   logic                          sof;
   logic                          long_len;
   logic                          zero_len;
   logic [wscfm_pkg::SEQ_W-1:0]   num_results;
   logic                          last;
   logic [1:0]                    pay_index;
   logic [15:0]                   pay_left;
   logic [15:0]                   pay_left_next;
   logic [7:0]                    masked;
   logic                          pay_done;
   logic [7:0]                    hdr_byte;
   logic [7:0]                    kb0;
   logic [7:0]                    kb1;
   logic [7:0]                    kb2;
   logic [7:0]                    kb3;

   assign sof      = item.start_of_frame;
   assign long_len = item.frame_length > wscfm_pkg::SHORT_LEN_MAX;
   assign zero_len = item.frame_length == 16'd0;

   assign kb0 = wscfm_pkg::key_byte(key, 2'd0);
   assign kb1 = wscfm_pkg::key_byte(key, 2'd1);
   assign kb2 = wscfm_pkg::key_byte(key, 2'd2);
   assign kb3 = wscfm_pkg::key_byte(key, 2'd3);

   assign pay_index     = sof ? 2'd0 : state.mask_index;
   assign pay_left      = sof ? item.frame_length : state.bytes_left;
   assign pay_left_next = pay_left - 16'd1;
   assign pay_done      = pay_left_next == 16'd0;
   assign masked        = item.data_byte ^ wscfm_pkg::key_byte(key, pay_index);

   always_comb begin
      if (!sof) begin
         num_results = SEQ_W_ONE;
      end else begin
         num_results = (long_len ? SEQ_W_EIGHT : SEQ_W_SIX)
                       + {{(wscfm_pkg::SEQ_W-1){1'b0}}, !zero_len};
      end
   end

   assign last = seq == (num_results - SEQ_W_ONE);

   always_comb begin
      case (seq)
         4'd0:    hdr_byte = wscfm_pkg::FRAME_FIN_TEXT;
         4'd1:    hdr_byte = long_len ? wscfm_pkg::LEN_EXT16
                                      : (item.frame_length[7:0] | wscfm_pkg::MASK_BIT);
         4'd2:    hdr_byte = long_len ? item.frame_length[15:8] : kb0;
         4'd3:    hdr_byte = long_len ? item.frame_length[7:0] : kb1;
         4'd4:    hdr_byte = long_len ? kb0 : kb2;
         4'd5:    hdr_byte = long_len ? kb1 : kb3;
         4'd6:    hdr_byte = long_len ? kb2 : masked;
         4'd7:    hdr_byte = kb3;
         4'd8:    hdr_byte = masked;
         default: hdr_byte = 8'h00;
      endcase
   end

   always_comb begin
      result.run_last = last;
      if (sof) begin
         result.out_byte    = hdr_byte;
         result.frame_done  = last && (zero_len || pay_done);
         result.stray_error = 1'b0;
      end else if (state.in_frame) begin
         result.out_byte    = masked;
         result.frame_done  = pay_done;
         result.stray_error = 1'b0;
      end else begin
         result.out_byte    = 8'h00;
         result.frame_done  = 1'b0;
         result.stray_error = 1'b1;
      end
   end

   always_comb begin
      if (sof && zero_len) begin
         state_next.bytes_left = 16'd0;
         state_next.mask_index = 2'd0;
         state_next.in_frame   = 1'b0;
      end else if (sof || state.in_frame) begin
         state_next.bytes_left = pay_left_next;
         state_next.mask_index = pay_index + 2'd1;
         state_next.in_frame   = !pay_done;
      end else begin
         state_next = state;
      end
   end

endmodule
